// ===== src/lpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfc_pkg: shared types and constants for the frame CRC checker
// Status codes, CRC constants and the result record passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  // Payload count never exceeds a length with bit 31 clear.
  localparam int unsigned CountW  = WordW - 1;

  localparam logic [WordW-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [WordW-1:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [StatusW-1:0] StatusMatch    = 2'd0;
  localparam logic [StatusW-1:0] StatusMismatch = 2'd1;
  localparam logic [StatusW-1:0] StatusBadLen   = 2'd2;

  // Output tdata: status, frame_length, computed_crc, received_crc, zero pad.
  localparam int unsigned ResultBits = StatusW + 3 * WordW;
  localparam int unsigned OutDataW   = ((ResultBits + ByteW - 1) / ByteW) * ByteW;

  typedef struct packed {
    logic               fire;
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   frame_length;
    logic [WordW-1:0]   computed_crc;
    logic [WordW-1:0]   received_crc;
  } result_t;

endpackage

`default_nettype wire

// ===== src/lpfc_crc_byte.sv =====
// ----------------------------------------------------------------------------
// lpfc_crc_byte: one-byte CRC-32 update
// Reflected CRC-32, eight bit steps folded into one combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfc_crc_byte (
  input  wire logic [lpfc_pkg::WordW-1:0] crc_in,
  input  wire logic [lpfc_pkg::ByteW-1:0] data_in,
  output logic      [lpfc_pkg::WordW-1:0] crc_out
);

  always_comb begin
    logic [lpfc_pkg::WordW-1:0] c;
    c = crc_in ^ {{(lpfc_pkg::WordW - lpfc_pkg::ByteW){1'b0}}, data_in};
    for (int k = 0; k < lpfc_pkg::ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ lpfc_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ===== src/lpfc_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// lpfc_frame_fsm: frame parser and checksum compare
// Holds phase, counter, length, running CRC and received checksum; advances
// one byte per step and flags a result when a frame or a bad length closes.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfc_frame_fsm (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [lpfc_pkg::ByteW-1:0] data_byte,
  output lpfc_pkg::result_t               res
);

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_t;

  phase_t                       phase_r,  phase_nxt;
  logic [lpfc_pkg::CountW-1:0]  cnt_r,    cnt_nxt;
  logic [lpfc_pkg::WordW-1:0]   len_r,    len_nxt;
  logic [lpfc_pkg::WordW-1:0]   crc_r,    crc_nxt;
  logic [lpfc_pkg::WordW-1:0]   chk_r,    chk_nxt;
  logic [lpfc_pkg::WordW-1:0]   crc_upd;
  logic [lpfc_pkg::WordW-1:0]   len_base;
  logic [lpfc_pkg::WordW-1:0]   len_shift;
  logic [lpfc_pkg::WordW-1:0]   chk_shift;
  logic [lpfc_pkg::WordW-1:0]   crc_final;
  logic [lpfc_pkg::CountW-1:0]  cnt_inc;

  lpfc_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (data_byte),
    .crc_out (crc_upd)
  );

  assign cnt_inc   = cnt_r + 1'b1;
  assign len_base  = (cnt_r == '0) ? '0 : len_r;
  assign len_shift = {len_base[lpfc_pkg::WordW-lpfc_pkg::ByteW-1:0], data_byte};
  assign chk_shift = {chk_r[lpfc_pkg::WordW-lpfc_pkg::ByteW-1:0], data_byte};
  assign crc_final = ~crc_r;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    chk_nxt   = chk_r;
    res       = '0;

    unique case (phase_r)
      PH_PAYLOAD: begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_inc;
        if (cnt_inc == len_r[lpfc_pkg::CountW-1:0]) begin
          phase_nxt = PH_CHECK;
          cnt_nxt   = '0;
          chk_nxt   = '0;
        end
      end
      PH_CHECK: begin
        chk_nxt = chk_shift;
        cnt_nxt = cnt_inc;
        if (cnt_r[1:0] == 2'd3) begin
          res.fire         = 1'b1;
          res.status       = (crc_final == chk_shift) ? lpfc_pkg::StatusMatch
                                                      : lpfc_pkg::StatusMismatch;
          res.frame_length = len_r;
          res.computed_crc = crc_final;
          res.received_crc = chk_shift;
          phase_nxt = PH_LENGTH;
          cnt_nxt   = '0;
          crc_nxt   = lpfc_pkg::CrcInit;
          chk_nxt   = '0;
        end
      end
      default: begin
        // Length phase; the unused phase code parses the same way.
        len_nxt   = len_shift;
        cnt_nxt   = cnt_inc;
        phase_nxt = PH_LENGTH;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt = '0;
          crc_nxt = lpfc_pkg::CrcInit;
          chk_nxt = '0;
          if (len_shift[lpfc_pkg::WordW-1]) begin
            res.fire         = 1'b1;
            res.status       = lpfc_pkg::StatusBadLen;
            res.frame_length = len_shift;
          end else begin
            phase_nxt = (len_shift == '0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
      end
    endcase

    if (!step) begin
      res.fire = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LENGTH;
      cnt_r   <= '0;
      len_r   <= '0;
      crc_r   <= lpfc_pkg::CrcInit;
      chk_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      chk_r   <= chk_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/length_prefixed_frame_crc_check_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_crc_check_core: length-prefixed frame CRC-32 checker
// Parses back-to-back frames (4-byte big-endian length, payload, 4-byte
// big-endian CRC-32) and reports match, mismatch or a bad length per frame.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Width  Contents
//  in_*      in   8      one stream byte per request
//  out_*     out  104    one status request per frame (or per bad length)
//
//  Flow: one byte per clock sustained while the result register is free or
//  being drained. A byte lands in the input register, then the parser and
//  byte-wide CRC update (one pass, 8 folded bit steps) consume it, writing
//  the result register when a frame closes or a length is bad. Result valid
//  is registered: it comes from that result register, not from the parser.
//  Reset: rst_n low clears the valid flags of both stages and puts the parser
//  in the length phase with the CRC preset to all ones.
//  Stalls: a result held in the output register stops the parser only while
//  out_tready is low; in_tready then drops once the input register is full.
//
`default_nettype none

module length_prefixed_frame_crc_check_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [lpfc_pkg::ByteW-1:0]    in_tdata,   // [7:0] data_byte

  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [1:0] status, [33:2] frame_length, [65:34] computed_crc,
  // [97:66] received_crc, [103:98] zero
  output logic [lpfc_pkg::OutDataW-1:0]      out_tdata
);

  logic                        in_vld_r;
  logic [lpfc_pkg::ByteW-1:0]  in_byte_r;
  logic                        out_vld_r;
  lpfc_pkg::result_t           out_res_r;
  lpfc_pkg::result_t           res;
  logic                        advance;

  // Consume the held byte whenever the result slot is free or being drained.
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  lpfc_frame_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .res       (res)
  );

  // Load a new result, or drop the shown one once the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res.fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(lpfc_pkg::OutDataW - lpfc_pkg::ResultBits){1'b0}},
                       out_res_r.received_crc,
                       out_res_r.computed_crc,
                       out_res_r.frame_length,
                       out_res_r.status};

endmodule

`default_nettype wire

// ===== tb/tb_length_prefixed_frame_crc_check_core.sv =====
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_crc_check_core: self-checking frame checker bench
// Streams length-prefixed frames (good, corrupted checksum, bad length, and an
// open frame at the end) into the core with random bursts and gaps. A local
// frame tracker predicts each status request, and a monitor compares every
// output request field by field while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_length_prefixed_frame_crc_check_core;

  localparam int unsigned ByteW    = lpfc_pkg::ByteW;
  localparam int unsigned WordW    = lpfc_pkg::WordW;
  localparam int unsigned StatusW  = lpfc_pkg::StatusW;
  localparam int unsigned OutDataW = lpfc_pkg::OutDataW;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned StreamBytes = 440;
  localparam int unsigned HoldoffAt   = 150;   // accepted bytes before the long stall
  localparam int unsigned HoldoffLen  = 400;   // cycles the receiver holds off

  // Field offsets inside out_tdata, lowest field first.
  localparam int unsigned LenLo = StatusW;
  localparam int unsigned CalLo = LenLo + WordW;
  localparam int unsigned RxLo  = CalLo + WordW;
  localparam int unsigned PadLo = RxLo + WordW;

  typedef enum logic [1:0] {
    PhaseLength  = 2'd0,
    PhasePayload = 2'd1,
    PhaseCheck   = 2'd2
  } parse_phase_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   frame_length;
    logic [WordW-1:0]   computed_crc;
    logic [WordW-1:0]   received_crc;
  } frame_verdict_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  logic [ByteW-1:0]    stream_q[$];     // bytes still to be offered
  frame_verdict_t      verdict_q[$];    // status requests the tracker expects
  int unsigned         fail_count = 0;
  int unsigned         cycles = 0;
  int unsigned         bytes_taken = 0;
  logic                in_fire = 1'b0;
  int unsigned         burst_left = 0;
  int unsigned         gap_left = 0;
  int unsigned         holdoff_left = 0;
  logic                holdoff_used = 1'b0;
  int unsigned         rx_mode = 0;
  int unsigned         rx_span = 0;

  // Frame tracker state.
  parse_phase_t        trk_phase = PhaseLength;
  logic [WordW-1:0]    trk_count = '0;
  logic [WordW-1:0]    trk_len = '0;
  logic [WordW-1:0]    trk_crc = lpfc_pkg::CrcInit;
  logic [WordW-1:0]    trk_chk = '0;

  always #2 clk = ~clk;

  length_prefixed_frame_crc_check_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Reflected CRC-32, one byte folded in.
  function automatic logic [WordW-1:0] crc32_next(logic [WordW-1:0] crc,
                                                  logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc ^ {{(WordW-ByteW){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ lpfc_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  task automatic restart_tracker();
    trk_phase = PhaseLength;
    trk_count = '0;
    trk_crc   = lpfc_pkg::CrcInit;
    trk_chk   = '0;
  endtask

  // Advance the tracker by one accepted byte; queue a verdict when a frame closes.
  task automatic track_frame_byte(input logic [ByteW-1:0] b);
    frame_verdict_t v;
    case (trk_phase)
      PhasePayload: begin
        trk_crc   = crc32_next(trk_crc, b);
        trk_count = trk_count + 1;
        if (trk_count == trk_len) begin
          trk_phase = PhaseCheck;
          trk_count = '0;
          trk_chk   = '0;
        end
      end
      PhaseCheck: begin
        trk_chk   = {trk_chk[WordW-ByteW-1:0], b};
        trk_count = trk_count + 1;
        if (trk_count == 4) begin
          v.computed_crc = ~trk_crc;
          v.received_crc = trk_chk;
          v.frame_length = trk_len;
          v.status       = (v.computed_crc == trk_chk) ? lpfc_pkg::StatusMatch
                                                       : lpfc_pkg::StatusMismatch;
          verdict_q.push_back(v);
          restart_tracker();
        end
      end
      default: begin
        // length phase; the unused phase code lands here as well
        if (trk_count == 0) trk_len = '0;
        trk_len   = {trk_len[WordW-ByteW-1:0], b};
        trk_count = trk_count + 1;
        if (trk_count == 4) begin
          if (trk_len[WordW-1]) begin
            v.status       = lpfc_pkg::StatusBadLen;
            v.frame_length = trk_len;
            v.computed_crc = '0;
            v.received_crc = '0;
            verdict_q.push_back(v);
            restart_tracker();
          end else begin
            trk_count = '0;
            trk_crc   = lpfc_pkg::CrcInit;
            trk_chk   = '0;
            trk_phase = (trk_len == 0) ? PhaseCheck : PhasePayload;
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    $display("mismatch on %s: got %h, want %h (cycle %0d)", what, got, want, cycles);
    fail_count++;
  endtask

  // Queue a 32-bit word most significant byte first.
  task automatic push_word(input logic [WordW-1:0] w);
    for (int i = 3; i >= 0; i--) stream_q.push_back(w[i*8 +: 8]);
  endtask

  // Queue one frame; a nonzero flip corrupts the carried checksum.
  task automatic add_frame(input logic [WordW-1:0] len, input bit all_ones,
                           input logic [WordW-1:0] flip);
    logic [WordW-1:0] crc;
    logic [ByteW-1:0] b;
    crc = lpfc_pkg::CrcInit;
    push_word(len);
    for (int unsigned i = 0; i < len; i++) begin
      b = all_ones ? 8'hFF : ByteW'($urandom());
      crc = crc32_next(crc, b);
      stream_q.push_back(b);
    end
    push_word(~crc ^ flip);
  endtask

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("length_prefixed_frame_crc_check_core regression: fail");
      $finish;
    end
  end

  // Sample both channels: predict on an accepted byte, check an accepted status request.
  always @(posedge clk) begin : watch
    frame_verdict_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      track_frame_byte(in_tdata);
      bytes_taken <= bytes_taken + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("status of a request with none expected",
                        WordW'(out_tdata[StatusW-1:0]), '0);
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[StatusW-1:0] != want.status)
          report_mismatch("status", WordW'(out_tdata[StatusW-1:0]), WordW'(want.status));
        if (out_tdata[LenLo +: WordW] != want.frame_length)
          report_mismatch("frame_length", out_tdata[LenLo +: WordW], want.frame_length);
        if (out_tdata[CalLo +: WordW] != want.computed_crc)
          report_mismatch("computed_crc", out_tdata[CalLo +: WordW], want.computed_crc);
        if (out_tdata[RxLo +: WordW] != want.received_crc)
          report_mismatch("received_crc", out_tdata[RxLo +: WordW], want.received_crc);
        if (out_tdata[OutDataW-1:PadLo] != '0)
          report_mismatch("pad bits", WordW'(out_tdata[OutDataW-1:PadLo]), '0);
      end
    end
  end

  // Long receiver hold-off, started once after enough bytes have gone in.
  always @(posedge clk) begin
    if (!holdoff_used && bytes_taken >= HoldoffAt) begin
      holdoff_left <= HoldoffLen;
      holdoff_used <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Sender: offer bytes in bursts, hold the request until it is taken, idle between bursts.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        in_tdata  <= stream_q.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switch between always ready, coin flip and sparse ready every span.
  always @(negedge clk) begin : rx_pattern
    logic pick;
    if (rx_span == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_span <= $urandom_range(16, 96);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      0:       pick = 1'b1;
      1:       pick = 1'($urandom_range(0, 1));
      default: pick = ($urandom_range(0, 7) == 0);
    endcase
    out_tready <= rst_n && (holdoff_left == 0) && pick;
  end

  initial begin
    logic [WordW-1:0] flip;
    logic [WordW-1:0] len;
    int unsigned      pick;

    // Directed: empty payload, both bad-length extremes, one all-ones byte.
    add_frame(32'd0, 1'b0, '0);
    push_word(32'hFFFF_FFFF);
    push_word(32'h8000_0000);
    add_frame(32'd1, 1'b1, '0);

    // Random frames: mostly well formed, some with broken checksums or bad lengths.
    while (stream_q.size() < StreamBytes) begin
      pick = $urandom_range(0, 19);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (pick < 14) begin
        add_frame(len, 1'b0, '0);
      end else if (pick < 17) begin
        flip = $urandom();
        if (flip == 0) flip = 32'h0000_0001;
        add_frame(len, 1'b0, flip);
      end else begin
        push_word($urandom() | 32'h8000_0000);
      end
    end

    // Leave a frame open with the largest legal length; it never closes.
    push_word(32'h7FFF_FFFF);
    repeat (6) stream_q.push_back(ByteW'($urandom()));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(stream_q.size() == 0 && !in_tvalid && verdict_q.size() == 0)) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("length_prefixed_frame_crc_check_core regression: pass");
    end else begin
      $display("length_prefixed_frame_crc_check_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/lpfc_pkg.sv
src/lpfc_crc_byte.sv
src/lpfc_frame_fsm.sv
src/length_prefixed_frame_crc_check_core.sv
tb/tb_length_prefixed_frame_crc_check_core.sv
